// ===== rtl/core/ldfp_pkg.sv =====
// ----------------------------------------------------------------------------
// LoRaWAN data frame parser package
// Shared constants, phase and class codes and the result item types.
// ----------------------------------------------------------------------------
package ldfp_pkg;

   // Length of the trailing integrity code in bytes.
   localparam int MIC_BYTES   = 4;
   // Largest number of result items that one input item can cause.
   localparam int MAX_RESULTS = MIC_BYTES + 1;

   localparam int FILL_W  = $clog2(MIC_BYTES + 1);
   localparam int COUNT_W = $clog2(MAX_RESULTS + 1);
   localparam int TAIL_W  = $clog2(MIC_BYTES);

   // Header bit that marks a supported frame type, and the option length mask.
   localparam logic [7:0] HDR_TYPE_MASK = 8'h40;
   localparam logic [7:0] OPTS_MASK     = 8'h0F;

   // Parser phases.
   localparam logic [2:0] PH_HDR  = 3'd0;
   localparam logic [2:0] PH_ADDR = 3'd1;
   localparam logic [2:0] PH_CTRL = 3'd2;
   localparam logic [2:0] PH_CNT  = 3'd3;
   localparam logic [2:0] PH_OPTS = 3'd4;
   localparam logic [2:0] PH_PORT = 3'd5;
   localparam logic [2:0] PH_BODY = 3'd6;
   localparam logic [2:0] PH_DROP = 3'd7;

   // Byte classes.
   localparam logic [3:0] CLS_HEADER    = 4'd0;
   localparam logic [3:0] CLS_ADDRESS   = 4'd1;
   localparam logic [3:0] CLS_CONTROL   = 4'd2;
   localparam logic [3:0] CLS_COUNTER   = 4'd3;
   localparam logic [3:0] CLS_OPTIONS   = 4'd4;
   localparam logic [3:0] CLS_PORT      = 4'd5;
   localparam logic [3:0] CLS_PAYLOAD   = 4'd6;
   localparam logic [3:0] CLS_CODE      = 4'd7;
   localparam logic [3:0] CLS_DISCARDED = 4'd8;

   // Frame status codes.
   localparam logic [1:0] ST_OK          = 2'd0;
   localparam logic [1:0] ST_UNSUPPORTED = 2'd1;
   localparam logic [1:0] ST_PORT_ZERO   = 2'd2;
   localparam logic [1:0] ST_TRUNCATED   = 2'd3;

   // One pending result item, without the frame fields shared by the burst.
   typedef struct packed {
      logic [7:0] value;
      logic [3:0] cls;
      logic [1:0] status;
      logic       done;
   } rsp_entry_type;

   // The result items caused by one input item.
   typedef struct packed {
      logic                                  load;
      logic [COUNT_W-1:0]                    count;
      rsp_entry_type [MAX_RESULTS-1:0]       entry;
   } rsp_burst_type;

   // Frame fields captured so far.
   typedef struct packed {
      logic [31:0] address;
      logic [15:0] counter;
      logic [7:0]  control;
      logic [7:0]  port;
   } frame_fields_type;

endpackage

// ===== rtl/core/ldfp_parser.sv =====
// ----------------------------------------------------------------------------
// LoRaWAN data frame parser: byte classifier
// Holds the input register and the frame state, and classifies one byte per
// cycle while the result queue can load, into a burst of up to five result items.
// ----------------------------------------------------------------------------
module ldfp_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      in_valid,
   output logic                      in_ready,
   input  logic [7:0]                in_byte,
   input  logic                      in_end,
   input  logic                      can_load,
   output ldfp_pkg::rsp_burst_type   burst,
   output ldfp_pkg::frame_fields_type fields
);
   import ldfp_pkg::*;

   logic                 valid_ff;
   logic [7:0]           byte_ff;
   logic                 end_ff;
   logic [2:0]           phase_ff, phase_in;
   logic [3:0]           field_count_ff, field_count_in;
   frame_fields_type     fields_ff, fields_in;
   logic [1:0]           error_ff, error_in;
   logic [FILL_W-1:0]    fill_ff, fill_in;
   logic [7:0]           tail_ff [MIC_BYTES];
   logic [7:0]           tail_in [MIC_BYTES];
   logic                 advance;
   logic [1:0]           end_status;

   assign advance  = valid_ff && can_load;
   assign in_ready = !valid_ff || can_load;
   assign fields   = fields_ff;

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_ready) begin
         valid_ff <= in_valid;
      end
      if (in_ready && in_valid) begin
         byte_ff <= in_byte;
         end_ff  <= in_end;
      end
   end

   // Classification of the registered byte.
   always_comb begin
      phase_in       = phase_ff;
      field_count_in = field_count_ff;
      fields_in      = fields_ff;
      error_in       = error_ff;
      fill_in        = fill_ff;
      tail_in        = tail_ff;
      end_status     = end_ff ? ST_TRUNCATED : ST_OK;
      burst          = '0;
      burst.load     = advance;
      burst.count    = COUNT_W'(1);
      burst.entry[0] = '{value: byte_ff, cls: CLS_DISCARDED, status: end_status,
                         done: end_ff};

      case (phase_ff)
         PH_ADDR: begin
            fields_in.address[field_count_ff[1:0]*8 +: 8] =
               fields_ff.address[field_count_ff[1:0]*8 +: 8] | byte_ff;
            field_count_in = field_count_ff + 4'd1;
            if (field_count_in >= 4'd4) begin
               field_count_in = '0;
               phase_in       = PH_CTRL;
            end
            burst.entry[0].cls = CLS_ADDRESS;
         end
         PH_CTRL: begin
            fields_in.control  = byte_ff;
            field_count_in     = '0;
            phase_in           = PH_CNT;
            burst.entry[0].cls = CLS_CONTROL;
         end
         PH_CNT: begin
            fields_in.counter[field_count_ff[0]*8 +: 8] =
               fields_ff.counter[field_count_ff[0]*8 +: 8] | byte_ff;
            field_count_in = field_count_ff + 4'd1;
            if (field_count_in >= 4'd2) begin
               field_count_in = '0;
               phase_in = ((fields_ff.control & OPTS_MASK) != 8'd0) ? PH_OPTS : PH_PORT;
            end
            burst.entry[0].cls = CLS_COUNTER;
         end
         PH_OPTS: begin
            field_count_in = field_count_ff + 4'd1;
            if (field_count_in >= fields_ff.control[3:0]) begin
               field_count_in = '0;
               phase_in       = PH_PORT;
            end
            burst.entry[0].cls = CLS_OPTIONS;
         end
         PH_PORT: begin
            fields_in.port = byte_ff;
            fill_in        = '0;
            if (byte_ff == 8'd0) begin
               error_in = ST_PORT_ZERO;
               phase_in = PH_DROP;
               if (end_ff) begin
                  burst.entry[0].status = ST_PORT_ZERO;
               end
            end else begin
               phase_in = PH_BODY;
            end
            burst.entry[0].cls = CLS_PORT;
         end
         PH_BODY: begin
            if (!end_ff) begin
               if (fill_ff >= FILL_W'(MIC_BYTES)) begin
                  // Delay line full: the oldest byte leaves as payload.
                  burst.entry[0] = '{value: tail_ff[0], cls: CLS_PAYLOAD,
                                     status: ST_OK, done: 1'b0};
                  for (int i = 0; i < MIC_BYTES - 1; i++) begin
                     tail_in[i] = tail_ff[i+1];
                  end
                  tail_in[MIC_BYTES-1] = byte_ff;
               end else begin
                  tail_in[fill_ff[TAIL_W-1:0]] = byte_ff;
                  fill_in     = fill_ff + FILL_W'(1);
                  burst.count = '0;
               end
            end else begin
               // Frame end: flush the delay line and the final byte.
               burst.count = COUNT_W'(fill_ff) + COUNT_W'(1);
               for (int i = 0; i < MAX_RESULTS; i++) begin
                  if (i < MIC_BYTES && FILL_W'(i) < fill_ff) begin
                     burst.entry[i].value = tail_ff[i];
                  end else begin
                     burst.entry[i].value = byte_ff;
                  end
                  burst.entry[i].done   = (FILL_W'(i) == fill_ff);
                  burst.entry[i].status = ST_OK;
                  if (fill_ff == FILL_W'(MIC_BYTES)) begin
                     burst.entry[i].cls = (i == 0) ? CLS_PAYLOAD : CLS_CODE;
                  end else if (fill_ff == FILL_W'(MIC_BYTES - 1)) begin
                     burst.entry[i].cls = CLS_CODE;
                  end else begin
                     burst.entry[i].cls = CLS_DISCARDED;
                     if (FILL_W'(i) == fill_ff) begin
                        burst.entry[i].status = ST_TRUNCATED;
                     end
                  end
               end
               fill_in = '0;
            end
         end
         PH_DROP: begin
            burst.entry[0].status = end_ff ? error_ff : ST_OK;
         end
         default: begin
            // Header byte opens a new frame.
            fields_in          = '0;
            fill_in            = '0;
            field_count_in     = '0;
            burst.entry[0].cls = CLS_HEADER;
            if ((byte_ff & HDR_TYPE_MASK) == 8'd0) begin
               error_in = ST_UNSUPPORTED;
               phase_in = PH_DROP;
               if (end_ff) begin
                  burst.entry[0].status = ST_UNSUPPORTED;
               end
            end else begin
               error_in = ST_OK;
               phase_in = PH_ADDR;
            end
         end
      endcase

      if (end_ff) begin
         phase_in       = PH_HDR;
         field_count_in = '0;
         fill_in        = '0;
      end
   end

   // Frame state, updated as each byte is classified.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= PH_HDR;
         field_count_ff <= '0;
         fields_ff      <= '0;
         error_ff       <= ST_OK;
         fill_ff        <= '0;
      end else if (advance) begin
         phase_ff       <= phase_in;
         field_count_ff <= field_count_in;
         fields_ff      <= fields_in;
         error_ff       <= error_in;
         fill_ff        <= fill_in;
      end
   end

   // Delay line for the trailing integrity code.
   always_ff @(posedge clock) begin
      if (advance) begin
         tail_ff <= tail_in;
      end
   end

endmodule

// ===== rtl/core/ldfp_result_queue.sv =====
// ----------------------------------------------------------------------------
// LoRaWAN data frame parser: result queue
// Holds the burst of result items for one byte and hands them out one per
// cycle on the result channel while the receiver is ready.
// ----------------------------------------------------------------------------
module ldfp_result_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  ldfp_pkg::rsp_burst_type burst,
   output logic                    can_load,
   output logic                    out_valid,
   input  logic                    out_ready,
   output ldfp_pkg::rsp_entry_type out_entry
);
   import ldfp_pkg::*;

   logic [COUNT_W-1:0]              count_ff, count_in;
   rsp_entry_type [MAX_RESULTS-1:0] entry_ff, entry_in;
   logic                            take;

   assign out_valid = (count_ff != '0);
   assign take      = out_valid && out_ready;
   assign can_load  = (count_ff == '0) || ((count_ff == COUNT_W'(1)) && out_ready);
   assign out_entry = entry_ff[0];

   // Load a new burst, or move the queue on by one item when one is taken.
   always_comb begin
      count_in = count_ff;
      entry_in = entry_ff;
      if (burst.load) begin
         count_in = burst.count;
         entry_in = burst.entry;
      end else if (take) begin
         count_in = count_ff - COUNT_W'(1);
         for (int i = 0; i < MAX_RESULTS - 1; i++) begin
            entry_in[i] = entry_ff[i+1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      entry_ff <= entry_in;
   end

endmodule

// ===== rtl/core/lorawan_data_frame_parser_unit.sv =====
// A byte is captured in the parser's input register, classified, and its
// result items are loaded into the result queue, which shows the first one.
// One byte per cycle while each byte causes at most one item and the receiver
// takes it. The last byte of a frame may cause up to five items, handed out one
// per cycle while the receiver is ready; the input waits until the last is taken.
// Reset is synchronous and clears the parser state and the queue; the
// integrity-code delay line is not cleared.
// ----------------------------------------------------------------------------
// LoRaWAN data frame parser unit
// Classifies the bytes of a data frame and reports the captured header fields
// and the frame status.
// ----------------------------------------------------------------------------
module lorawan_data_frame_parser_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tlast,   // frame_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] byte_value, [39:8] device_address, [55:40] frame_count,
   // [63:56] frame_control, [71:64] port_number, [73:72] status, rest zero
   output logic [79:0] rsp_tdata,
   output logic [3:0]  rsp_tuser,   // [3:0] byte_class
   output logic        rsp_tlast    // frame_done
);
   import ldfp_pkg::*;

   rsp_burst_type    burst;
   frame_fields_type fields;
   rsp_entry_type    head;
   logic             can_load;

   ldfp_parser u_parser (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_end   (req_tlast),
      .can_load (can_load),
      .burst    (burst),
      .fields   (fields)
   );

   ldfp_result_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .burst     (burst),
      .can_load  (can_load),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_entry (head)
   );

   // Result item packing.
   assign rsp_tdata = {6'd0, head.status, fields.port, fields.control,
                       fields.counter, fields.address, head.value};
   assign rsp_tuser = head.cls;
   assign rsp_tlast = head.done;

endmodule

// ===== rtl/core/ldfp_checker.sv =====
// ----------------------------------------------------------------------------
// LoRaWAN data frame parser checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module ldfp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [79:0] rsp_tdata,
   input logic [3:0]  rsp_tuser,
   input logic        rsp_tlast
);
   import ldfp_pkg::*;

   // A stalled result item holds still.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
         && $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("result item changed while stalled");

   // The queue is empty straight after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item shown after reset");

   // Only the last item of a frame carries a status.
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> rsp_tdata[73:72] == ST_OK)
      else $error("status set on an item that does not end the frame");

   // The port item shows its own byte as the captured port.
   a_port_capture: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == CLS_PORT |-> rsp_tdata[71:64] == rsp_tdata[7:0])
      else $error("captured port differs from the port byte");

endmodule

bind lorawan_data_frame_parser_unit ldfp_checker u_ldfp_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// ===== dv/tb_lorawan_data_frame_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the LoRaWAN data frame parser unit
// Feeds frames byte by byte, first from a short table of hand-picked frames
// and then as random frames (mostly well formed, some cut short, some with an
// unsupported header). Every result item is compared field by field with a
// typed-in table row or with a behavioural parser in the testbench. Both sides
// of the stream idle at random, except in the last of three random phases.
// ----------------------------------------------------------------------------
module tb_lorawan_data_frame_parser_unit;
   import ldfp_pkg::*;

   localparam int RANDOM_ITEMS = 440;
   localparam int CYCLE_LIMIT  = 200000;

   // One classified byte as the parser should report it.
   typedef struct packed {
      logic [7:0]  value;
      logic [3:0]  cls;
      logic [31:0] address;
      logic [15:0] counter;
      logic [7:0]  control;
      logic [7:0]  port;
      logic [1:0]  status;
      logic        done;
   } classified_byte_type;

   // One row of the hand-picked frames; class and status are used only when
   // the row carries its own typed-in result.
   typedef struct packed {
      logic [7:0] data;
      logic       frame_end;
      logic       typed;
      logic [3:0] cls;
      logic [1:0] status;
   } frame_row_type;

   localparam int ROWS = 29;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [79:0] rsp_tdata;
   logic [3:0]  rsp_tuser;
   logic        rsp_tlast;

   classified_byte_type expected_bytes[$];
   int fail_count;
   int sent_items;
   int send_idle_pct;
   int recv_idle_pct;
   int cycle_count;

   // Behavioural parser state.
   logic [2:0]  parse_phase;
   logic [3:0]  field_idx;
   logic [31:0] address_acc;
   logic [15:0] counter_acc;
   logic [7:0]  control_cap;
   logic [7:0]  port_cap;
   logic [7:0]  mic_window[MIC_BYTES];
   logic [2:0]  mic_fill;
   logic [1:0]  frame_error;

   frame_row_type frame_rows[ROWS] = '{
      // Unsupported header that is also the last byte.
      '{8'h00, 1'b1, 1'b1, CLS_HEADER, ST_UNSUPPORTED},
      // Supported header cut short at once.
      '{8'hFF, 1'b1, 1'b1, CLS_HEADER, ST_TRUNCATED},
      // Unsupported header, then a discarded byte.
      '{8'hBF, 1'b0, 1'b1, CLS_HEADER, ST_OK},
      '{8'h55, 1'b1, 1'b1, CLS_DISCARDED, ST_UNSUPPORTED},
      // No options, port zero on the last byte.
      '{8'h40, 1'b0, 1'b1, CLS_HEADER, ST_OK},
      '{8'h01, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'h02, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'h03, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'h04, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'h00, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hAA, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hBB, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'h00, 1'b1, 1'b0, 4'd0, 2'd0},
      // Complete frame: one option, one payload byte and the integrity code.
      '{8'hC0, 1'b0, 1'b1, CLS_HEADER, ST_OK},
      '{8'hFF, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hFF, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hFF, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hFF, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'h81, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hFF, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hFF, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hEE, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'h01, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'h10, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hA1, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hA2, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hA3, 1'b0, 1'b0, 4'd0, 2'd0},
      '{8'hA4, 1'b1, 1'b0, 4'd0, 2'd0},
      // Supported header that is also the last byte of its frame.
      '{8'h7F, 1'b1, 1'b1, CLS_HEADER, ST_TRUNCATED}
   };

   lorawan_data_frame_parser_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   // Free-running clock with a 20 ns period.
   always #10 clock = ~clock;

   // Records one classified byte with the frame fields captured so far.
   function automatic void note_byte(input logic [7:0] value, input logic [3:0] cls,
                                     input logic [1:0] status, input logic done,
                                     input bit keep);
      if (keep) begin
         expected_bytes.push_back('{value, cls, address_acc, counter_acc,
                                    control_cap, port_cap, status, done});
      end
   endfunction

   // Advances the behavioural parser by one byte and queues what it emits.
   function automatic void classify_byte(input logic [7:0] data, input logic frame_end,
                                         input bit keep);
      logic [7:0] tail[MIC_BYTES+1];
      int         total;
      logic [3:0] cls;
      logic [1:0] status;
      case (parse_phase)
         PH_ADDR: begin
            address_acc = address_acc | (32'(data) << (8 * field_idx[1:0]));
            field_idx = field_idx + 4'd1;
            if (field_idx >= 4'd4) begin
               field_idx = 4'd0;
               parse_phase = PH_CTRL;
            end
            note_byte(data, CLS_ADDRESS, frame_end ? ST_TRUNCATED : ST_OK, frame_end, keep);
         end
         PH_CTRL: begin
            control_cap = data;
            field_idx = 4'd0;
            parse_phase = PH_CNT;
            note_byte(data, CLS_CONTROL, frame_end ? ST_TRUNCATED : ST_OK, frame_end, keep);
         end
         PH_CNT: begin
            counter_acc = counter_acc | (16'(data) << (8 * field_idx[0]));
            field_idx = field_idx + 4'd1;
            if (field_idx >= 4'd2) begin
               field_idx = 4'd0;
               parse_phase = ((control_cap & OPTS_MASK) != 8'd0) ? PH_OPTS : PH_PORT;
            end
            note_byte(data, CLS_COUNTER, frame_end ? ST_TRUNCATED : ST_OK, frame_end, keep);
         end
         PH_OPTS: begin
            field_idx = field_idx + 4'd1;
            if (field_idx >= control_cap[3:0]) begin
               field_idx = 4'd0;
               parse_phase = PH_PORT;
            end
            note_byte(data, CLS_OPTIONS, frame_end ? ST_TRUNCATED : ST_OK, frame_end, keep);
         end
         PH_PORT: begin
            port_cap = data;
            mic_fill = 3'd0;
            if (data == 8'd0) begin
               frame_error = ST_PORT_ZERO;
               parse_phase = PH_DROP;
            end else begin
               parse_phase = PH_BODY;
            end
            status = !frame_end ? ST_OK : (data == 8'd0) ? ST_PORT_ZERO : ST_TRUNCATED;
            note_byte(data, CLS_PORT, status, frame_end, keep);
         end
         PH_BODY: begin
            if (!frame_end) begin
               // Hold back the newest bytes until the frame end shows which
               // of them form the integrity code.
               if (mic_fill >= MIC_BYTES) begin
                  note_byte(mic_window[0], CLS_PAYLOAD, ST_OK, 1'b0, keep);
                  for (int i = 0; i < MIC_BYTES - 1; i++) mic_window[i] = mic_window[i+1];
                  mic_window[MIC_BYTES-1] = data;
               end else begin
                  mic_window[mic_fill] = data;
                  mic_fill = mic_fill + 3'd1;
               end
            end else begin
               total = (mic_fill > MIC_BYTES) ? MIC_BYTES : int'(mic_fill);
               for (int i = 0; i < total; i++) tail[i] = mic_window[i];
               tail[total] = data;
               total++;
               for (int i = 0; i < total; i++) begin
                  status = ST_OK;
                  if (total == MIC_BYTES + 1) begin
                     cls = (i == 0) ? CLS_PAYLOAD : CLS_CODE;
                  end else if (total == MIC_BYTES) begin
                     cls = CLS_CODE;
                  end else begin
                     // Too short for an integrity code: flush as discarded.
                     cls = CLS_DISCARDED;
                     if (i == total - 1) status = ST_TRUNCATED;
                  end
                  note_byte(tail[i], cls, status, i == total - 1, keep);
               end
               mic_fill = 3'd0;
            end
         end
         PH_DROP: begin
            note_byte(data, CLS_DISCARDED, frame_end ? frame_error : ST_OK, frame_end, keep);
         end
         default: begin
            // Header byte: a new frame starts from cleared fields.
            address_acc = '0;
            counter_acc = '0;
            control_cap = '0;
            port_cap = '0;
            mic_fill = 3'd0;
            field_idx = 4'd0;
            if ((data & HDR_TYPE_MASK) == 8'd0) begin
               frame_error = ST_UNSUPPORTED;
               parse_phase = PH_DROP;
               note_byte(data, CLS_HEADER, frame_end ? ST_UNSUPPORTED : ST_OK,
                         frame_end, keep);
            end else begin
               frame_error = ST_OK;
               parse_phase = PH_ADDR;
               note_byte(data, CLS_HEADER, frame_end ? ST_TRUNCATED : ST_OK,
                         frame_end, keep);
            end
         end
      endcase
      if (frame_end) begin
         parse_phase = PH_HDR;
         field_idx = 4'd0;
         mic_fill = 3'd0;
      end
   endfunction

   // Offers one byte, waits for it to be taken and predicts its results.
   task automatic send_byte(input logic [7:0] data, input logic frame_end, input bit keep);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tlast  <= frame_end;
      do @(posedge clock); while (!req_tready);
      classify_byte(data, frame_end, keep);
      sent_items++;
   endtask

   // Builds one random frame and sends it, possibly cut short.
   task automatic send_random_frame();
      logic [7:0] frame_bytes[$];
      logic [3:0] opts_len;
      int         kind;
      int         payload_len;
      int         length;
      kind = $urandom_range(99);
      if (kind < 12) begin
         // Unsupported frame type followed by a few bytes of noise.
         frame_bytes.push_back(8'($urandom) & ~HDR_TYPE_MASK);
         repeat ($urandom_range(5)) frame_bytes.push_back(8'($urandom));
      end else begin
         frame_bytes.push_back(8'($urandom) | HDR_TYPE_MASK);
         repeat (4) frame_bytes.push_back(8'($urandom));
         opts_len = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(2));
         frame_bytes.push_back({4'($urandom), opts_len});
         repeat (2) frame_bytes.push_back(8'($urandom));
         repeat (opts_len) frame_bytes.push_back(8'($urandom));
         frame_bytes.push_back(($urandom_range(9) == 0) ? 8'd0 : 8'($urandom_range(1, 255)));
         payload_len = $urandom_range(8);
         repeat (payload_len + MIC_BYTES) frame_bytes.push_back(8'($urandom));
      end
      length = frame_bytes.size();
      if ($urandom_range(99) < 25) length = $urandom_range(1, frame_bytes.size());
      for (int i = 0; i < length; i++) send_byte(frame_bytes[i], i == length - 1, 1'b1);
   endtask

   // Compares one field of a result item.
   task automatic check_field(input string name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (actual !== expected) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, expected, actual);
         fail_count++;
      end
   endtask

   // Receiver stalls at random.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
   end

   // Every accepted result item is checked against the oldest prediction.
   always @(posedge clock) begin
      classified_byte_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_bytes.size() == 0) begin
            $error("result item 0x%0h with no prediction waiting", rsp_tdata[7:0]);
            fail_count++;
         end else begin
            want = expected_bytes.pop_front();
            check_field("byte_value", want.value, rsp_tdata[7:0]);
            check_field("byte_class", want.cls, rsp_tuser);
            check_field("device_address", want.address, rsp_tdata[39:8]);
            check_field("frame_count", want.counter, rsp_tdata[55:40]);
            check_field("frame_control", want.control, rsp_tdata[63:56]);
            check_field("port_number", want.port, rsp_tdata[71:64]);
            check_field("status", want.status, rsp_tdata[73:72]);
            check_field("frame_done", want.done, rsp_tlast);
            check_field("tdata_padding", 32'd0, rsp_tdata[79:74]);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("tb_lorawan_data_frame_parser_unit NOT OK");
      $finish;
   end

   // Main sequence: reset, hand-picked frames, random frames, drain.
   initial begin
      int random_start;
      clock         = 1'b0;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = 8'd0;
      req_tlast     = 1'b0;
      rsp_tready    = 1'b0;
      fail_count    = 0;
      sent_items    = 0;
      send_idle_pct = 17;
      recv_idle_pct = 68;
      parse_phase   = PH_HDR;
      field_idx     = 4'd0;
      address_acc   = '0;
      counter_acc   = '0;
      control_cap   = '0;
      port_cap      = '0;
      mic_fill      = 3'd0;
      frame_error   = ST_OK;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Hand-picked frames; typed-in rows bypass the predicted result.
      foreach (frame_rows[i]) begin
         if (frame_rows[i].typed) begin
            expected_bytes.push_back('{frame_rows[i].data, frame_rows[i].cls, 32'd0, 16'd0,
                                       8'd0, 8'd0, frame_rows[i].status,
                                       frame_rows[i].frame_end});
         end
         send_byte(frame_rows[i].data, frame_rows[i].frame_end, !frame_rows[i].typed);
      end

      // Random frames over three idling phases.
      random_start = sent_items;
      while (sent_items - random_start < RANDOM_ITEMS) begin
         if (sent_items - random_start < RANDOM_ITEMS / 3) begin
            send_idle_pct = 17;
            recv_idle_pct = 68;
         end else if (sent_items - random_start < 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 68;
            recv_idle_pct = 17;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         send_random_frame();
      end
      req_tvalid <= 1'b0;

      // Drain the outstanding results, then allow for the pipeline latency.
      while (expected_bytes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (fail_count == 0 && expected_bytes.size() == 0) begin
         $display("tb_lorawan_data_frame_parser_unit OK");
      end else begin
         $display("tb_lorawan_data_frame_parser_unit NOT OK");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/core/ldfp_pkg.sv
rtl/core/ldfp_parser.sv
rtl/core/ldfp_result_queue.sv
rtl/core/lorawan_data_frame_parser_unit.sv
rtl/core/ldfp_checker.sv
dv/tb_lorawan_data_frame_parser_unit.sv
